@@ rtl/prt_pkg.sv @@
`timescale 1ns / 1ps

package prt_pkg;

  // Store geometry and field widths.
  localparam int MAX_ELEMENTS = 64;
  localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
  localparam int POS_W        = 7;
  localparam int VAL_W        = 8;
  localparam int SIZE_W       = 7;
  localparam int PASS_W       = 2;

  // Input and output tdata widths.
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  // Configuration register indexes.
  localparam logic CFG_SIZE = 1'b0;
  localparam logic CFG_MODE = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(15);
  localparam logic              MODE_RESET = 1'b1;

  // Reversal passes: a transposition runs three, a reversal only the last.
  localparam logic [PASS_W-1:0] PASS_FIRST  = 2'd0;
  localparam logic [PASS_W-1:0] PASS_SECOND = 2'd1;
  localparam logic [PASS_W-1:0] PASS_LAST   = 2'd2;

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [POS_W-1:0]        pos_t;
  typedef logic [ADDR_W-1:0]       addr_t;

  typedef enum logic [1:0] {
    ACT_RESTORE   = 2'd0,
    ACT_READ      = 2'd1,
    ACT_REVERSE   = 2'd2,
    ACT_TRANSPOSE = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_ISSUE,
    ST_RD_DATA,
    ST_ISSUE,
    ST_WR_LO,
    ST_WR_HI,
    ST_DONE
  } state_t;

  // Request from the sequencer to the permutation store.
  typedef struct packed {
    logic   clear;
    logic   rd_en;
    addr_t  rd_addr_a;
    addr_t  rd_addr_b;
    logic   wr_en;
    addr_t  wr_addr;
    value_t wr_data;
  } store_req_t;

  // Positions are 1-based; the store is addressed from zero.
  function automatic addr_t pos_addr(input pos_t pos);
    pos_t p;
    p = pos - POS_W'(1);
    return p[ADDR_W-1:0];
  endfunction

endpackage

@@ rtl/permutation_reversal_transposition_core.sv @@
`timescale 1ns / 1ps

// Signed permutation store with read, restore, reversal and transposition.
// Input stream (in_*): one transaction per command; in_tready is high only
// while the block is idle. Output stream (out_*): exactly one transaction
// per command, carrying the entry read (zero otherwise) and an error flag
// for positions out of range, in which case the store is left unchanged.
// Configuration (cfg_*): index 0 sets the element count, index 1 the mode
// (1 keeps signs, 0 negates reversed entries); write only while idle.
// A reversal swaps pairs from both ends inward, and a transposition runs
// three such passes (two blocks, then the whole span). The single write
// port of the store sets the pace: every pair swap is a read of both
// entries followed by two writes, one per entry. The block is idle again,
// ready for the next command, once a result is placed in the output
// register, even if the receiver has not taken it. When the receiver
// stalls, a finished command waits until the output register frees. Reset
// loads the identity at once (per-entry valid bits) and sets the count to
// 15 and the mode to keep signs.
module permutation_reversal_transposition_core (
  input  logic                           clk,
  input  logic                           rst_n,
  // tdata: action[1:0], first_pos[8:2], second_pos[15:9], third_pos[22:16]
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [prt_pkg::IN_DATA_W-1:0]  in_tdata,
  // tdata: entry_value[7:0], status[8]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [prt_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [prt_pkg::SIZE_W-1:0]     cfg_wdata
);

  logic [prt_pkg::SIZE_W-1:0] size_r;
  logic                       mode_r;
  prt_pkg::store_req_t        req;
  prt_pkg::value_t            rd_a;
  prt_pkg::value_t            rd_b;
  prt_pkg::value_t            entry_value;
  logic                       status;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= prt_pkg::SIZE_RESET;
      mode_r <= prt_pkg::MODE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        prt_pkg::CFG_SIZE: size_r <= cfg_wdata;
        prt_pkg::CFG_MODE: mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  prt_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .size_in_use    (size_r),
    .unsigned_mode  (mode_r),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_action      (prt_pkg::act_t'(in_tdata[1:0])),
    .in_first_pos   (in_tdata[8:2]),
    .in_second_pos  (in_tdata[15:9]),
    .in_third_pos   (in_tdata[22:16]),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_entry_value(entry_value),
    .out_status     (status),
    .req            (req),
    .rd_a           (rd_a),
    .rd_b           (rd_b)
  );

  prt_store u_store (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  assign out_tdata = {(prt_pkg::OUT_DATA_W - prt_pkg::VAL_W - 1)'(0), status, entry_value};

`ifndef SYNTHESIS
  // A rejected command never carries an entry value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[prt_pkg::VAL_W] |-> out_tdata[prt_pkg::VAL_W-1:0] == '0)
    else $error("error result carries a nonzero entry value");

  // One command at a time: acceptance drops ready for the next cycle.
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready stayed high after a command was accepted");

  // The swap unit never reads and writes the store in the same cycle.
  a_no_rw: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.rd_en && req.wr_en))
    else $error("store read and write issued together");

  // The store is only touched while a command is in flight.
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && !in_tvalid |-> !req.wr_en && !req.rd_en && !req.clear)
    else $error("store access while idle");
`endif

endmodule

@@ rtl/prt_ram.sv @@
`timescale 1ns / 1ps

// Generic RAM: one write port, two read ports with registered read data.
module prt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ rtl/prt_store.sv @@
`timescale 1ns / 1ps

// Permutation store: RAM plus one valid bit per entry. An entry that has
// not been written since reset or the last restore reads as the identity.
module prt_store (
  input  logic                clk,
  input  logic                rst_n,
  input  prt_pkg::store_req_t req,
  output prt_pkg::value_t     rd_a,
  output prt_pkg::value_t     rd_b
);

  logic [prt_pkg::MAX_ELEMENTS-1:0] valid_r;
  logic [prt_pkg::MAX_ELEMENTS-1:0] valid_nxt;
  prt_pkg::addr_t                   addr_a_r;
  prt_pkg::addr_t                   addr_b_r;
  logic                             vld_a_r;
  logic                             vld_b_r;
  logic [prt_pkg::VAL_W-1:0]        ram_a;
  logic [prt_pkg::VAL_W-1:0]        ram_b;

  prt_ram #(
    .WIDTH(prt_pkg::VAL_W),
    .DEPTH(prt_pkg::MAX_ELEMENTS)
  ) u_ram (
    .clk    (clk),
    .we     (req.wr_en),
    .waddr  (req.wr_addr),
    .wdata  (req.wr_data),
    .re     (req.rd_en),
    .raddr_a(req.rd_addr_a),
    .raddr_b(req.rd_addr_b),
    .rdata_a(ram_a),
    .rdata_b(ram_b)
  );

  // Valid bits: cleared by reset and restore, set by every write.
  always_comb begin
    valid_nxt = valid_r;
    if (req.clear) begin
      valid_nxt = '0;
    end else if (req.wr_en) begin
      valid_nxt[req.wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Address and valid bit follow the registered read data.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      addr_a_r <= req.rd_addr_a;
      addr_b_r <= req.rd_addr_b;
      vld_a_r  <= valid_r[req.rd_addr_a];
      vld_b_r  <= valid_r[req.rd_addr_b];
    end
  end

  assign rd_a = vld_a_r ? prt_pkg::value_t'(ram_a)
                        : prt_pkg::value_t'(prt_pkg::VAL_W'(addr_a_r) + prt_pkg::VAL_W'(1));
  assign rd_b = vld_b_r ? prt_pkg::value_t'(ram_b)
                        : prt_pkg::value_t'(prt_pkg::VAL_W'(addr_b_r) + prt_pkg::VAL_W'(1));

endmodule

@@ rtl/prt_seq.sv @@
`timescale 1ns / 1ps

// Sequencer: checks positions, then drives the shared swap unit over the
// store. A reversal swaps pairs from both ends inward; a transposition is
// three reversals (first block, second block, whole span) without negation.
module prt_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [prt_pkg::SIZE_W-1:0] size_in_use,
  input  logic                       unsigned_mode,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  prt_pkg::act_t              in_action,
  input  prt_pkg::pos_t              in_first_pos,
  input  prt_pkg::pos_t              in_second_pos,
  input  prt_pkg::pos_t              in_third_pos,
  output logic                       out_valid,
  input  logic                       out_ready,
  output prt_pkg::value_t            out_entry_value,
  output logic                       out_status,
  output prt_pkg::store_req_t        req,
  input  prt_pkg::value_t            rd_a,
  input  prt_pkg::value_t            rd_b
);

  prt_pkg::state_t              state_r, state_nxt;
  prt_pkg::pos_t                i_r, i_nxt;
  prt_pkg::pos_t                j_r, j_nxt;
  prt_pkg::pos_t                k_r, k_nxt;
  prt_pkg::pos_t                x_r, x_nxt;
  prt_pkg::pos_t                y_r, y_nxt;
  logic [prt_pkg::PASS_W-1:0]   pass_r, pass_nxt;
  logic                         neg_r, neg_nxt;
  logic                         status_r, status_nxt;
  prt_pkg::value_t              value_r, value_nxt;
  logic                         out_valid_r, out_valid_nxt;
  prt_pkg::value_t              out_value_r, out_value_nxt;
  logic                         out_status_r, out_status_nxt;

  logic [prt_pkg::SIZE_W-1:0]   n;
  logic [prt_pkg::SIZE_W:0]     n_plus1;
  logic                         rd_ok;
  logic                         rev_ok;
  logic                         tr_ok;
  logic                         seg_done;

  // Clamp the element count into 1..MAX_ELEMENTS.
  always_comb begin
    if (size_in_use == '0) begin
      n = prt_pkg::SIZE_W'(1);
    end else if (size_in_use > prt_pkg::SIZE_W'(prt_pkg::MAX_ELEMENTS)) begin
      n = prt_pkg::SIZE_W'(prt_pkg::MAX_ELEMENTS);
    end else begin
      n = size_in_use;
    end
  end

  assign n_plus1 = {1'b0, n} + (prt_pkg::SIZE_W+1)'(1);

  // Position checks on the incoming transaction.
  assign rd_ok  = (in_first_pos != '0) && (in_first_pos <= n);
  assign rev_ok = (in_first_pos != '0) && (in_first_pos <= in_second_pos) &&
                  (in_second_pos <= n);
  assign tr_ok  = (in_first_pos != '0) && (in_first_pos < in_second_pos) &&
                  (in_second_pos < in_third_pos) && ({1'b0, in_third_pos} <= n_plus1);

  // Next state and store requests.
  always_comb begin
    state_nxt      = state_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    k_nxt          = k_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    pass_nxt       = pass_r;
    neg_nxt        = neg_r;
    status_nxt     = status_r;
    value_nxt      = value_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    seg_done       = 1'b0;
    in_ready       = 1'b0;
    req            = '0;
    req.rd_addr_a  = prt_pkg::pos_addr(x_r);
    req.rd_addr_b  = prt_pkg::pos_addr(y_r);
    req.wr_addr    = prt_pkg::pos_addr(x_r);
    req.wr_data    = neg_r ? -rd_b : rd_b;

    unique case (state_r)
      prt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          i_nxt      = in_first_pos;
          j_nxt      = in_second_pos;
          k_nxt      = in_third_pos;
          status_nxt = 1'b0;
          value_nxt  = '0;
          unique case (in_action)
            prt_pkg::ACT_RESTORE: begin
              req.clear = 1'b1;
              state_nxt = prt_pkg::ST_DONE;
            end
            prt_pkg::ACT_READ: begin
              if (rd_ok) begin
                state_nxt = prt_pkg::ST_RD_ISSUE;
              end else begin
                status_nxt = 1'b1;
                state_nxt  = prt_pkg::ST_DONE;
              end
            end
            prt_pkg::ACT_REVERSE: begin
              if (rev_ok) begin
                x_nxt     = in_first_pos;
                y_nxt     = in_second_pos;
                neg_nxt   = !unsigned_mode;
                pass_nxt  = prt_pkg::PASS_LAST;
                state_nxt = prt_pkg::ST_ISSUE;
              end else begin
                status_nxt = 1'b1;
                state_nxt  = prt_pkg::ST_DONE;
              end
            end
            prt_pkg::ACT_TRANSPOSE: begin
              if (tr_ok) begin
                x_nxt     = in_first_pos;
                y_nxt     = in_second_pos - prt_pkg::POS_W'(1);
                neg_nxt   = 1'b0;
                pass_nxt  = prt_pkg::PASS_FIRST;
                state_nxt = prt_pkg::ST_ISSUE;
              end else begin
                status_nxt = 1'b1;
                state_nxt  = prt_pkg::ST_DONE;
              end
            end
            default: state_nxt = prt_pkg::ST_DONE;
          endcase
        end
      end
      prt_pkg::ST_RD_ISSUE: begin
        req.rd_en     = 1'b1;
        req.rd_addr_a = prt_pkg::pos_addr(i_r);
        state_nxt     = prt_pkg::ST_RD_DATA;
      end
      prt_pkg::ST_RD_DATA: begin
        value_nxt = rd_a;
        state_nxt = prt_pkg::ST_DONE;
      end
      prt_pkg::ST_ISSUE: begin
        req.rd_en = 1'b1;
        state_nxt = prt_pkg::ST_WR_LO;
      end
      prt_pkg::ST_WR_LO: begin
        // Lower position takes the upper value; the middle maps onto itself.
        req.wr_en = 1'b1;
        if (x_r == y_r) begin
          seg_done = 1'b1;
        end else begin
          state_nxt = prt_pkg::ST_WR_HI;
        end
      end
      prt_pkg::ST_WR_HI: begin
        req.wr_en   = 1'b1;
        req.wr_addr = prt_pkg::pos_addr(y_r);
        req.wr_data = neg_r ? -rd_a : rd_a;
        x_nxt       = x_r + prt_pkg::POS_W'(1);
        y_nxt       = y_r - prt_pkg::POS_W'(1);
        if (x_r + prt_pkg::POS_W'(2) <= y_r) begin
          state_nxt = prt_pkg::ST_ISSUE;
        end else begin
          seg_done = 1'b1;
        end
      end
      prt_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = value_r;
          out_status_nxt = status_r;
          state_nxt      = prt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = prt_pkg::ST_IDLE;
    endcase

    // End of one reversal pass: start the next span or finish.
    if (seg_done) begin
      priority if (pass_r == prt_pkg::PASS_FIRST) begin
        x_nxt     = j_r;
        y_nxt     = k_r - prt_pkg::POS_W'(1);
        pass_nxt  = prt_pkg::PASS_SECOND;
        state_nxt = prt_pkg::ST_ISSUE;
      end else if (pass_r == prt_pkg::PASS_SECOND) begin
        x_nxt     = i_r;
        y_nxt     = k_r - prt_pkg::POS_W'(1);
        pass_nxt  = prt_pkg::PASS_LAST;
        state_nxt = prt_pkg::ST_ISSUE;
      end else begin
        state_nxt = prt_pkg::ST_DONE;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= prt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    k_r          <= k_nxt;
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    pass_r       <= pass_nxt;
    neg_r        <= neg_nxt;
    status_r     <= status_nxt;
    value_r      <= value_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_entry_value = out_value_r;
  assign out_status      = out_status_r;

endmodule

@@ verif/tb_permutation_reversal_transposition_core.sv @@
`timescale 1ns / 1ps

// Tracks the signed permutation held by the block and checks every result
// transaction against the oldest predicted one.
class perm_tracker;
  typedef struct {
    logic [prt_pkg::VAL_W-1:0] entry_value;
    logic                      status;
  } cmd_result_t;

  int                         perm [prt_pkg::MAX_ELEMENTS + 1];
  logic [prt_pkg::SIZE_W-1:0] size_reg;
  logic                       keep_sign;
  cmd_result_t                pending_results [$];
  int                         errors;

  function new();
    size_reg  = prt_pkg::SIZE_RESET;
    keep_sign = prt_pkg::MODE_RESET;
    errors    = 0;
    load_identity();
  endfunction

  function void load_identity();
    for (int m = 0; m <= prt_pkg::MAX_ELEMENTS; m++) begin
      perm[m] = m;
    end
  endfunction

  // A count of zero acts as one, and counts past the store act as full.
  function int live_size();
    if (size_reg < 1) return 1;
    if (size_reg > prt_pkg::MAX_ELEMENTS) return prt_pkg::MAX_ELEMENTS;
    return size_reg;
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  function void write_reg(logic idx, logic [prt_pkg::SIZE_W-1:0] val);
    if (idx == prt_pkg::CFG_SIZE) size_reg = val;
    else keep_sign = val[0];
  endfunction

  // Applies one accepted command to the permutation and queues its result.
  function void note_command(prt_pkg::act_t act, int i, int j, int k);
    cmd_result_t res;
    int          snap [prt_pkg::MAX_ELEMENTS + 1];
    int          n;
    int          y;
    n               = live_size();
    res.entry_value = '0;
    res.status      = 1'b0;
    case (act)
      prt_pkg::ACT_RESTORE: begin
        load_identity();
      end
      prt_pkg::ACT_READ: begin
        if (i >= 1 && i <= n) res.entry_value = perm[i][prt_pkg::VAL_W-1:0];
        else res.status = 1'b1;
      end
      prt_pkg::ACT_REVERSE: begin
        if (i >= 1 && i <= j && j <= n) begin
          snap = perm;
          for (int x = i; x <= j; x++) begin
            perm[x] = keep_sign ? snap[i + j - x] : -snap[i + j - x];
          end
        end else begin
          res.status = 1'b1;
        end
      end
      default: begin
        if (i >= 1 && i < j && j < k && k <= n + 1) begin
          snap = perm;
          y    = i + (k - j);
          for (int x = i; x < j; x++) begin
            perm[y] = snap[x];
            y++;
          end
          y = i;
          for (int x = j; x < k; x++) begin
            perm[y] = snap[x];
            y++;
          end
        end else begin
          res.status = 1'b1;
        end
      end
    endcase
    pending_results.push_back(res);
  endfunction

  function void check_result(logic [prt_pkg::OUT_DATA_W-1:0] tdata);
    cmd_result_t want;
    if (pending_results.size() == 0) begin
      $error("out_tdata: transaction 0x%h arrived with no command pending", tdata);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    if (tdata[7:0] !== want.entry_value) begin
      $error("entry_value: expected %0d, got %0d",
             $signed(want.entry_value), $signed(tdata[7:0]));
      errors++;
    end
    if (tdata[8] !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, tdata[8]);
      errors++;
    end
  endfunction
endclass

module tb_permutation_reversal_transposition_core;

  localparam int LIMIT_CYCLES    = 1_000_000;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 88;

  logic                           clk;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [prt_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [prt_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           cfg_we     = 1'b0;
  logic                           cfg_index  = prt_pkg::CFG_SIZE;
  logic [prt_pkg::SIZE_W-1:0]     cfg_wdata  = '0;

  logic [15:0]                    stall_mask  = '0;
  logic [3:0]                     ready_phase = '0;
  int                             cycle_count = 0;
  int                             burst_left  = 0;
  bit                             gaps_on     = 1'b1;
  perm_tracker                    tracker;

  permutation_reversal_transposition_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Result side: check each accepted transaction and stall on the mask.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_result(out_tdata);
    out_tready  <= !stall_mask[ready_phase];
    ready_phase <= ready_phase + 4'd1;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Presents one command and holds it until accepted, then maybe pauses.
  task automatic send_command(input prt_pkg::act_t act, input prt_pkg::pos_t i,
                              input prt_pkg::pos_t j, input prt_pkg::pos_t k);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, k, j, i, act};
    do @(posedge clk); while (in_tready !== 1'b1);
    tracker.note_command(act, i, j, k);
    if (burst_left > 0) begin
      burst_left--;
    end else if (gaps_on) begin
      burst_left = $urandom_range(0, 11);
      gap        = $urandom_range(1, 10);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Waits until every result is back and the block has settled.
  task automatic drain();
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(input logic [prt_pkg::SIZE_W-1:0] size, input logic keep_sign);
    logic [prt_pkg::SIZE_W-2:0] junk;
    junk       = (prt_pkg::SIZE_W-1)'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= prt_pkg::CFG_SIZE;
    cfg_wdata <= size;
    @(posedge clk);
    tracker.write_reg(prt_pkg::CFG_SIZE, size);
    cfg_index <= prt_pkg::CFG_MODE;
    cfg_wdata <= {junk, keep_sign};
    @(posedge clk);
    tracker.write_reg(prt_pkg::CFG_MODE, {junk, keep_sign});
    cfg_we    <= 1'b0;
  endtask

  // A position that is likely out of range, or anything at all.
  function automatic prt_pkg::pos_t stray_pos(int n);
    case ($urandom_range(0, 4))
      0: return prt_pkg::pos_t'(0);
      1: return prt_pkg::pos_t'(n);
      2: return prt_pkg::pos_t'(n + 1);
      3: return prt_pkg::pos_t'(n + 2);
      default: return prt_pkg::pos_t'($urandom_range(0, 127));
    endcase
  endfunction

  // Mostly well-formed commands with random positions, some noise.
  task automatic random_command();
    int            n;
    int            pick;
    bit            sane;
    prt_pkg::pos_t i;
    prt_pkg::pos_t j;
    prt_pkg::pos_t k;
    n    = tracker.live_size();
    pick = $urandom_range(0, 99);
    sane = ($urandom_range(0, 99) < 85);
    i    = stray_pos(n);
    j    = stray_pos(n);
    k    = stray_pos(n);
    if (pick < 3) begin
      send_command(prt_pkg::ACT_RESTORE, i, j, k);
    end else if (pick < 28) begin
      if (sane) i = prt_pkg::pos_t'($urandom_range(1, n));
      send_command(prt_pkg::ACT_READ, i, j, k);
    end else if (pick < 62) begin
      if (sane) begin
        i = prt_pkg::pos_t'($urandom_range(1, n));
        j = prt_pkg::pos_t'($urandom_range(i, n));
      end
      send_command(prt_pkg::ACT_REVERSE, i, j, k);
    end else begin
      if (sane && n >= 2) begin
        i = prt_pkg::pos_t'($urandom_range(1, n - 1));
        j = prt_pkg::pos_t'($urandom_range(i + 1, n));
        k = prt_pkg::pos_t'($urandom_range(j + 1, n + 1));
      end
      send_command(prt_pkg::ACT_TRANSPOSE, i, j, k);
    end
  endtask

  initial begin
    logic [prt_pkg::SIZE_W-1:0] size;
    logic                       keep_sign;
    tracker = new();
    repeat (3) @(posedge clk);
    rst_n      <= 1'b1;
    stall_mask <= 16'h0421;
    @(posedge clk);

    // Directed commands at the reset setting of 15 elements, signs kept.
    send_command(prt_pkg::ACT_READ, 7'd1, 7'd0, 7'd0);
    send_command(prt_pkg::ACT_READ, 7'd15, 7'd0, 7'd0);
    send_command(prt_pkg::ACT_READ, 7'd0, 7'd0, 7'd0);
    send_command(prt_pkg::ACT_READ, 7'd16, 7'd0, 7'd0);
    send_command(prt_pkg::ACT_READ, 7'd127, 7'd127, 7'd127);
    send_command(prt_pkg::ACT_REVERSE, 7'd1, 7'd15, 7'd0);
    send_command(prt_pkg::ACT_REVERSE, 7'd5, 7'd5, 7'd0);
    send_command(prt_pkg::ACT_REVERSE, 7'd3, 7'd2, 7'd0);
    send_command(prt_pkg::ACT_REVERSE, 7'd0, 7'd3, 7'd0);
    send_command(prt_pkg::ACT_REVERSE, 7'd1, 7'd16, 7'd0);
    send_command(prt_pkg::ACT_TRANSPOSE, 7'd1, 7'd2, 7'd16);
    send_command(prt_pkg::ACT_TRANSPOSE, 7'd1, 7'd8, 7'd16);
    send_command(prt_pkg::ACT_TRANSPOSE, 7'd2, 7'd2, 7'd5);
    send_command(prt_pkg::ACT_TRANSPOSE, 7'd1, 7'd5, 7'd5);
    send_command(prt_pkg::ACT_TRANSPOSE, 7'd1, 7'd5, 7'd17);
    send_command(prt_pkg::ACT_TRANSPOSE, 7'd0, 7'd1, 7'd2);
    send_command(prt_pkg::ACT_TRANSPOSE, 7'd127, 7'd127, 7'd127);
    send_command(prt_pkg::ACT_READ, 7'd1, 7'd0, 7'd0);
    send_command(prt_pkg::ACT_READ, 7'd8, 7'd0, 7'd0);
    send_command(prt_pkg::ACT_RESTORE, 7'd127, 7'd127, 7'd127);
    send_command(prt_pkg::ACT_READ, 7'd15, 7'd0, 7'd0);
    in_tvalid <= 1'b0;

    // Random phases, each under its own setting and idle pattern. One slot
    // of the receiver pattern always stays ready so a result never waits
    // forever.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph)
        0: begin size = 7'd64;  keep_sign = 1'b0; end
        1: begin size = 7'd1;   keep_sign = 1'b1; end
        2: begin size = 7'd0;   keep_sign = 1'b0; end
        3: begin size = 7'd127; keep_sign = 1'b1; end
        4: begin size = 7'd64;  keep_sign = 1'b1; end
        5: begin
          size = prt_pkg::SIZE_W'($urandom_range(2, 63));
          keep_sign = 1'b0;
        end
        6: begin
          size = prt_pkg::SIZE_W'($urandom_range(0, 127));
          keep_sign = 1'($urandom);
        end
        default: begin size = 7'd2; keep_sign = 1'b0; end
      endcase
      configure(size, keep_sign);
      case (ph % 3)
        0: stall_mask <= '0;
        1: stall_mask <= 16'($urandom) & 16'($urandom) & 16'hFFFE;
        default: stall_mask <= 16'($urandom) & 16'hFFFE;
      endcase
      gaps_on    = (ph % 4 != 1);
      burst_left = 0;
      repeat (ITEMS_PER_PHASE) random_command();
      in_tvalid <= 1'b0;
    end

    while (tracker.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

@@ permutation_reversal_transposition_core.f @@
rtl/prt_pkg.sv
rtl/prt_ram.sv
rtl/prt_store.sv
rtl/prt_seq.sv
rtl/permutation_reversal_transposition_core.sv
verif/tb_permutation_reversal_transposition_core.sv
